@@ hdl/chc_pkg.sv @@
// shared types for the monotone-chain convex hull block
`default_nettype none
package chc_pkg;

	// operation applied to every cell of a row of point cells together
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH,
		OP_POP,
		OP_INSERT,
		OP_CLEAR
	} row_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_TEST,
		ST_MUL,
		ST_DEC,
		ST_DROP,
		ST_MOVE,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

@@ hdl/chc_cell.sv @@
// one point cell of a shift row: holds a point, shifts, pushes, pops or sorts in
`default_nettype none
module chc_cell #(
	parameter int CW = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire chc_pkg::row_op_t  op,
	input  wire logic [2*CW-1:0]   new_d,
	input  wire logic [2*CW-1:0]   left_d,
	input  wire logic              left_v,
	input  wire logic              left_b,
	input  wire logic [2*CW-1:0]   right_d,
	input  wire logic              right_v,
	output logic      [2*CW-1:0]   d,
	output logic                   v,
	output logic                   b
);

	logic signed [CW-1:0] nx, ny, cx, cy;
	logic                 take_left, take_new, take_right;

	assign nx = new_d[2*CW-1:CW];
	assign ny = new_d[CW-1:0];
	assign cx = d[2*CW-1:CW];
	assign cy = d[CW-1:0];

	// new point sorts ahead of this cell (empty cells are always behind)
	assign b = !v || ((nx == cx) ? (ny < cy) : (nx < cx));

	always_comb begin
		take_left  = 1'b0;
		take_new   = 1'b0;
		take_right = 1'b0;
		case (op)
			chc_pkg::OP_PUSH:   take_left = 1'b1;
			chc_pkg::OP_POP:    take_right = 1'b1;
			chc_pkg::OP_INSERT: begin
				if (b) begin
					take_left = left_b;
					take_new  = !left_b;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take_left) begin
			d <= left_d;
		end else if (take_new) begin
			d <= new_d;
		end else if (take_right) begin
			d <= right_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= 1'b0;
		end else if (op == chc_pkg::OP_CLEAR) begin
			v <= 1'b0;
		end else if (take_left) begin
			v <= left_v;
		end else if (take_new) begin
			v <= 1'b1;
		end else if (take_right) begin
			v <= right_v;
		end
	end

endmodule
`default_nettype wire

@@ hdl/convex_hull_monotone_chain.sv @@
// top level of the monotone-chain convex hull engine built from rows of point cells
//
// usage: points enter one per transaction while start is high and busy is low;
// last_point marks the final point of a set and starts the hull. each hull
// vertex leaves as one transaction on vertex_x/vertex_y, marked by result_strobe
// for one cycle, lower chain first then upper chain (counter-clockwise);
// last_vertex marks the final vertex. fewer than three points gives a single
// transaction with hull_empty set. points past MAX_POINTS are dropped and
// points_dropped is reported on every vertex of that set.
// steps: each of the two chain passes pushes without a test while its chain holds
// fewer than two points; every other push and every chain pop follows a
// cross-product test in a shared two-multiplier unit; the pass then sees itself
// done, drops the chain end and reverses the chain, vertex by vertex, into an
// empty row; then the vertices are emitted one by one. a set of fewer than three
// points keeps busy high for one cycle.
// reset: all rows empty, point count and overflow cleared; no clearing pass.
// the receiver cannot stall: each vertex is shown for exactly one cycle.
`default_nettype none
module convex_hull_monotone_chain #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic               last_point,
	output logic                    result_strobe,
	output logic signed [31:0]      vertex_x,
	output logic signed [31:0]      vertex_y,
	output logic                    last_vertex,
	output logic                    hull_empty,
	output logic                    points_dropped
);

	localparam int CW    = COORD_BITS;
	localparam int DW    = 2 * CW;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int PW    = 2 * (CW + 1);

	chc_pkg::state_t  state_q, state_nxt;
	chc_pkg::row_op_t srt_op, rev_op, chn_op;

	// three rows: sorted input, reversed copy, and the chain stack (top at cell 0)
	logic [DW-1:0] srt_d [MAX_POINTS];
	logic [DW-1:0] rev_d [MAX_POINTS];
	logic [DW-1:0] chn_d [MAX_POINTS];
	logic [MAX_POINTS-1:0] srt_v, rev_v, chn_v, srt_b, rev_b, chn_b;
	logic [DW-1:0] srt_new, rev_new, chn_new;

	logic [CNT_W-1:0] count_q;
	logic             ovf_q, drop_q, upper_q;
	logic             accept, full;
	logic [DW-1:0]    in_pt, cand;
	logic             cand_v;

	// cross-product unit: differences, then products, then compare
	logic signed [CW:0]   dx1_s1, dy1_s1, dx2_s1, dy2_s1;
	logic signed [PW-1:0] p_s2, q_s2;
	logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
	logic                 not_left;

	// emit controls
	logic          emit_en, emit_last, emit_empty;
	logic [DW-1:0] emit_d;

	assign busy   = (state_q != chc_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(MAX_POINTS));
	assign in_pt  = {point_x[CW-1:0], point_y[CW-1:0]};

	// candidate point of the current pass
	assign cand   = upper_q ? rev_d[0] : srt_d[0];
	assign cand_v = upper_q ? rev_v[0] : srt_v[0];

	genvar gi;
	generate
		for (gi = 0; gi < MAX_POINTS; gi++) begin : g_cells
			if (gi == 0) begin : g_head
				chc_cell #(.CW(CW)) u_srt (
					.clk(clk), .arst_n(arst_n), .op(srt_op), .new_d(srt_new),
					.left_d(srt_new), .left_v(1'b1), .left_b(1'b0),
					.right_d(srt_d[(gi + 1) % MAX_POINTS]),
					.right_v((MAX_POINTS > 1) ? srt_v[(gi + 1) % MAX_POINTS] : 1'b0),
					.d(srt_d[gi]), .v(srt_v[gi]), .b(srt_b[gi]));
				chc_cell #(.CW(CW)) u_rev (
					.clk(clk), .arst_n(arst_n), .op(rev_op), .new_d(rev_new),
					.left_d(rev_new), .left_v(1'b1), .left_b(1'b0),
					.right_d(rev_d[(gi + 1) % MAX_POINTS]),
					.right_v((MAX_POINTS > 1) ? rev_v[(gi + 1) % MAX_POINTS] : 1'b0),
					.d(rev_d[gi]), .v(rev_v[gi]), .b(rev_b[gi]));
				chc_cell #(.CW(CW)) u_chn (
					.clk(clk), .arst_n(arst_n), .op(chn_op), .new_d(chn_new),
					.left_d(chn_new), .left_v(1'b1), .left_b(1'b0),
					.right_d(chn_d[(gi + 1) % MAX_POINTS]),
					.right_v((MAX_POINTS > 1) ? chn_v[(gi + 1) % MAX_POINTS] : 1'b0),
					.d(chn_d[gi]), .v(chn_v[gi]), .b(chn_b[gi]));
			end else if (gi == MAX_POINTS - 1) begin : g_tail
				chc_cell #(.CW(CW)) u_srt (
					.clk(clk), .arst_n(arst_n), .op(srt_op), .new_d(srt_new),
					.left_d(srt_d[gi - 1]), .left_v(srt_v[gi - 1]), .left_b(srt_b[gi - 1]),
					.right_d(srt_new), .right_v(1'b0),
					.d(srt_d[gi]), .v(srt_v[gi]), .b(srt_b[gi]));
				chc_cell #(.CW(CW)) u_rev (
					.clk(clk), .arst_n(arst_n), .op(rev_op), .new_d(rev_new),
					.left_d(rev_d[gi - 1]), .left_v(rev_v[gi - 1]), .left_b(rev_b[gi - 1]),
					.right_d(rev_new), .right_v(1'b0),
					.d(rev_d[gi]), .v(rev_v[gi]), .b(rev_b[gi]));
				chc_cell #(.CW(CW)) u_chn (
					.clk(clk), .arst_n(arst_n), .op(chn_op), .new_d(chn_new),
					.left_d(chn_d[gi - 1]), .left_v(chn_v[gi - 1]), .left_b(chn_b[gi - 1]),
					.right_d(chn_new), .right_v(1'b0),
					.d(chn_d[gi]), .v(chn_v[gi]), .b(chn_b[gi]));
			end else begin : g_mid
				chc_cell #(.CW(CW)) u_srt (
					.clk(clk), .arst_n(arst_n), .op(srt_op), .new_d(srt_new),
					.left_d(srt_d[gi - 1]), .left_v(srt_v[gi - 1]), .left_b(srt_b[gi - 1]),
					.right_d(srt_d[gi + 1]), .right_v(srt_v[gi + 1]),
					.d(srt_d[gi]), .v(srt_v[gi]), .b(srt_b[gi]));
				chc_cell #(.CW(CW)) u_rev (
					.clk(clk), .arst_n(arst_n), .op(rev_op), .new_d(rev_new),
					.left_d(rev_d[gi - 1]), .left_v(rev_v[gi - 1]), .left_b(rev_b[gi - 1]),
					.right_d(rev_d[gi + 1]), .right_v(rev_v[gi + 1]),
					.d(rev_d[gi]), .v(rev_v[gi]), .b(rev_b[gi]));
				chc_cell #(.CW(CW)) u_chn (
					.clk(clk), .arst_n(arst_n), .op(chn_op), .new_d(chn_new),
					.left_d(chn_d[gi - 1]), .left_v(chn_v[gi - 1]), .left_b(chn_b[gi - 1]),
					.right_d(chn_d[gi + 1]), .right_v(chn_v[gi + 1]),
					.d(chn_d[gi]), .v(chn_v[gi]), .b(chn_b[gi]));
			end
		end
	endgenerate

	// turn test operands: below = chain cell 1, top = chain cell 0, new = candidate
	assign ax = chn_d[1][DW-1:CW];
	assign ay = chn_d[1][CW-1:0];
	assign bx = chn_d[0][DW-1:CW];
	assign by = chn_d[0][CW-1:0];
	assign cx = cand[DW-1:CW];
	assign cy = cand[CW-1:0];

	always_ff @(posedge clk) begin
		dx1_s1 <= (CW + 1)'(bx) - (CW + 1)'(ax);
		dy1_s1 <= (CW + 1)'(by) - (CW + 1)'(ay);
		dx2_s1 <= (CW + 1)'(cx) - (CW + 1)'(ax);
		dy2_s1 <= (CW + 1)'(cy) - (CW + 1)'(ay);
		p_s2   <= PW'(dx1_s1) * PW'(dy2_s1);
		q_s2   <= PW'(dy1_s1) * PW'(dx2_s1);
	end

	// cross product zero or negative: pop the chain top
	assign not_left = (p_s2 <= q_s2);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			chc_pkg::ST_IDLE: begin
				if (accept && last_point) begin
					state_nxt = (count_q < CNT_W'(2)) ? chc_pkg::ST_CLEAR : chc_pkg::ST_TEST;
				end
			end
			chc_pkg::ST_CLEAR: state_nxt = chc_pkg::ST_IDLE;
			chc_pkg::ST_TEST: begin
				if (!cand_v) begin
					state_nxt = chc_pkg::ST_DROP;
				end else if (chn_v[1]) begin
					state_nxt = chc_pkg::ST_MUL;
				end
			end
			chc_pkg::ST_MUL: state_nxt = chc_pkg::ST_DEC;
			chc_pkg::ST_DEC: state_nxt = chc_pkg::ST_TEST;
			chc_pkg::ST_DROP: state_nxt = chc_pkg::ST_MOVE;
			chc_pkg::ST_MOVE: begin
				if (!chn_v[0]) begin
					state_nxt = upper_q ? chc_pkg::ST_EMIT : chc_pkg::ST_TEST;
				end
			end
			chc_pkg::ST_EMIT: begin
				if (emit_last) begin
					state_nxt = chc_pkg::ST_IDLE;
				end
			end
			default: state_nxt = chc_pkg::ST_IDLE;
		endcase
	end

	// row operations and emit controls
	always_comb begin
		srt_op     = chc_pkg::OP_HOLD;
		rev_op     = chc_pkg::OP_HOLD;
		chn_op     = chc_pkg::OP_HOLD;
		srt_new    = chn_d[0];
		rev_new    = cand;
		chn_new    = cand;
		emit_en    = 1'b0;
		emit_last  = 1'b0;
		emit_empty = 1'b0;
		emit_d     = srt_d[0];
		unique case (state_q)
			chc_pkg::ST_IDLE: begin
				srt_new = in_pt;
				if (accept && !full) begin
					srt_op = chc_pkg::OP_INSERT;
				end
				if (accept && last_point && count_q < CNT_W'(2)) begin
					emit_en    = 1'b1;
					emit_last  = 1'b1;
					emit_empty = 1'b1;
				end
			end
			chc_pkg::ST_CLEAR: srt_op = chc_pkg::OP_CLEAR;
			chc_pkg::ST_TEST: begin
				// chain shorter than two: push without a test
				if (cand_v && !chn_v[1]) begin
					chn_op = chc_pkg::OP_PUSH;
					if (upper_q) begin
						rev_op = chc_pkg::OP_POP;
					end else begin
						srt_op = chc_pkg::OP_POP;
						rev_op = chc_pkg::OP_PUSH;
					end
				end
			end
			chc_pkg::ST_DEC: begin
				if (not_left) begin
					chn_op = chc_pkg::OP_POP;
				end else begin
					chn_op = chc_pkg::OP_PUSH;
					if (upper_q) begin
						rev_op = chc_pkg::OP_POP;
					end else begin
						srt_op = chc_pkg::OP_POP;
						rev_op = chc_pkg::OP_PUSH;
					end
				end
			end
			chc_pkg::ST_DROP: chn_op = chc_pkg::OP_POP;
			chc_pkg::ST_MOVE: begin
				// reverse the chain into an empty row so it reads bottom first
				rev_new = chn_d[0];
				if (chn_v[0]) begin
					chn_op = chc_pkg::OP_POP;
					if (upper_q) begin
						rev_op = chc_pkg::OP_PUSH;
					end else begin
						srt_op = chc_pkg::OP_PUSH;
					end
				end
			end
			chc_pkg::ST_EMIT: begin
				emit_en = 1'b1;
				if (srt_v[0]) begin
					srt_op    = chc_pkg::OP_POP;
					emit_d    = srt_d[0];
					emit_last = !srt_v[1] && !rev_v[0];
				end else begin
					rev_op    = chc_pkg::OP_POP;
					emit_d    = rev_d[0];
					emit_last = !rev_v[1];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chc_pkg::ST_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
			drop_q  <= 1'b0;
			upper_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				if (last_point) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					drop_q  <= ovf_q || full;
					upper_q <= 1'b0;
				end else if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (state_q == chc_pkg::ST_MOVE && !chn_v[0]) begin
				upper_q <= 1'b1;
			end
		end
	end

	// result registers: each transaction shows for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= emit_en;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			vertex_x       <= emit_empty ? '0 : 32'(signed'(emit_d[DW-1:CW]));
			vertex_y       <= emit_empty ? '0 : 32'(signed'(emit_d[CW-1:0]));
			last_vertex    <= emit_last;
			hull_empty     <= emit_empty;
			points_dropped <= emit_empty ? (ovf_q || full) : drop_q;
		end
	end

endmodule
`default_nettype wire

@@ tb/sv/convex_hull_monotone_chain_test.sv @@
// testbench for the monotone-chain convex hull block: directed and random point sets
`timescale 1ns / 100ps
`default_nettype none
module convex_hull_monotone_chain_test;

	localparam int CAP = 64;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               last;
		logic               empty;
		logic               dropped;
	} vertex_t;

	typedef struct {
		longint x;
		longint y;
	} pt_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic               last_point;
	logic               result_strobe;
	logic signed [31:0] vertex_x;
	logic signed [31:0] vertex_y;
	logic               last_vertex;
	logic               hull_empty;
	logic               points_dropped;

	convex_hull_monotone_chain dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point_x(point_x), .point_y(point_y), .last_point(last_point),
		.result_strobe(result_strobe), .vertex_x(vertex_x), .vertex_y(vertex_y),
		.last_vertex(last_vertex), .hull_empty(hull_empty),
		.points_dropped(points_dropped)
	);

	// predictor state: the stored set and the overflow mark
	pt_t     set_pts[CAP];
	int      set_count;
	bit      set_overflow;
	vertex_t hull_queue[$];
	bit      failed;
	int      idle_pct;
	int      quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// exact sign of the cross product (b - a) x (c - a): true when <= 0
	function automatic bit turns_right_or_straight(pt_t a, pt_t b, pt_t c);
		logic signed [127:0] p;
		logic signed [127:0] q;
		p = 128'(signed'(b.x - a.x)) * 128'(signed'(c.y - a.y));
		q = 128'(signed'(b.y - a.y)) * 128'(signed'(c.x - a.x));
		return (p - q) <= 0;
	endfunction

	function automatic bit sorts_ahead(pt_t a, pt_t b);
		if (a.x == b.x)
			return a.y < b.y;
		return a.x < b.x;
	endfunction

	// hull of the stored set, appended to the expected vertex queue
	task automatic predict_hull();
		int    n;
		int    j;
		int    lo_n;
		int    up_n;
		int    k;
		int    lo[CAP];
		int    up[CAP];
		pt_t   v;
		pt_t   s[CAP];
		vertex_t r;
		n = set_count;
		r.dropped = set_overflow;
		set_count = 0;
		set_overflow = 0;
		if (n < 3) begin
			r.x = 0; r.y = 0; r.last = 1; r.empty = 1;
			hull_queue = {hull_queue, r};
			return;
		end
		for (int i = 0; i < n; i++) s[i] = set_pts[i];
		// stable insertion sort
		for (int i = 1; i < n; i++) begin
			v = s[i];
			j = i;
			while (j > 0 && sorts_ahead(v, s[j - 1])) begin
				s[j] = s[j - 1];
				j--;
			end
			s[j] = v;
		end
		lo_n = 0;
		for (int i = 0; i < n; i++) begin
			while (lo_n >= 2 && turns_right_or_straight(s[lo[lo_n - 2]], s[lo[lo_n - 1]], s[i]))
				lo_n--;
			lo[lo_n++] = i;
		end
		up_n = 0;
		for (int i = n - 1; i >= 0; i--) begin
			while (up_n >= 2 && turns_right_or_straight(s[up[up_n - 2]], s[up[up_n - 1]], s[i]))
				up_n--;
			up[up_n++] = i;
		end
		r.empty = 0;
		r.last = 0;
		k = 0;
		for (int i = 0; i + 1 < lo_n && k < 64; i++, k++) begin
			r.x = s[lo[i]].x; r.y = s[lo[i]].y;
			hull_queue = {hull_queue, r};
		end
		for (int i = 0; i + 1 < up_n && k < 64; i++, k++) begin
			r.x = s[up[i]].x; r.y = s[up[i]].y;
			hull_queue = {hull_queue, r};
		end
		if (k > 0)
			hull_queue[hull_queue.size() - 1].last = 1;
	endtask

	// one point transaction, with random idle cycles ahead of it
	task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
			input bit fin);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		point_x <= x;
		point_y <= y;
		last_point <= fin;
		@(posedge clk);
		while (busy) @(posedge clk);
		// accepted at this edge: update predictor
		if (set_count < CAP) begin
			set_pts[set_count].x = x;
			set_pts[set_count].y = y;
			set_count++;
		end else begin
			set_overflow = 1;
		end
		if (fin)
			predict_hull();
	endtask

	// stop sending and wait for every expected vertex to arrive
	task automatic drain();
		start <= 1'b0;
		while (hull_queue.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return $signed($urandom_range(40)) - 20;
			default: return $signed($urandom_range(2000)) - 1000;
		endcase
	endfunction

	// each result strobe is checked against the oldest expected vertex
	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && result_strobe) begin
			if (hull_queue.size() == 0) begin
				$error("unexpected vertex x=%0d y=%0d", vertex_x, vertex_y);
				failed = 1;
			end else begin
				e = hull_queue.pop_front();
				if (vertex_x !== e.x) begin
					$error("vertex_x expected %0d actual %0d", e.x, vertex_x); failed = 1;
				end
				if (vertex_y !== e.y) begin
					$error("vertex_y expected %0d actual %0d", e.y, vertex_y); failed = 1;
				end
				if (last_vertex !== e.last) begin
					$error("last_vertex expected %0d actual %0d", e.last, last_vertex);
					failed = 1;
				end
				if (hull_empty !== e.empty) begin
					$error("hull_empty expected %0d actual %0d", e.empty, hull_empty);
					failed = 1;
				end
				if (points_dropped !== e.dropped) begin
					$error("points_dropped expected %0d actual %0d", e.dropped,
						points_dropped);
					failed = 1;
				end
			end
		end
	end

	// watchdog: cycles with no transaction in either direction
	always @(posedge clk) begin
		if (!arst_n || result_strobe || (start && !busy))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 40000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// small sets: one and two points, coincident, collinear, and a triangle
	task automatic test_small_sets();
		send_point(5, 5, 1);
		send_point(1, 2, 0); send_point(3, 4, 1);
		send_point(7, 7, 0); send_point(7, 7, 0); send_point(7, 7, 1);
		send_point(0, 0, 0); send_point(2, 2, 0); send_point(1, 1, 0);
		send_point(3, 3, 1);
		send_point(0, 0, 0); send_point(4, 0, 0); send_point(2, 3, 1);
	endtask

	// coordinate extremes stress the exact cross product
	task automatic test_extremes();
		send_point(32'h8000_0000, 32'h8000_0000, 0);
		send_point(32'h7fff_ffff, 32'h8000_0000, 0);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 0);
		send_point(32'h8000_0000, 32'h7fff_ffff, 0);
		send_point(0, 0, 0);
		send_point(32'hffff_ffff, 32'h0000_0001, 1);
	endtask

	// a full store and beyond: extra points dropped and flagged
	task automatic test_overflow();
		for (int i = 0; i < CAP + 3; i++)
			send_point(rand_coord(2), rand_coord(2), i == CAP + 2);
		drain();
		for (int i = 0; i < CAP; i++)
			send_point(rand_coord(1), rand_coord(1), i == CAP - 1);
	endtask

	// random sets, mostly small, with varied coordinate ranges
	task automatic test_random_sets(input int items);
		int n;
		int mode;
		int sent;
		sent = 0;
		while (sent < items) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(70, 30) : $urandom_range(8, 1);
			mode = $urandom_range(2);
			for (int i = 0; i < n; i++)
				send_point(rand_coord(mode), rand_coord(mode), i == n - 1);
			sent += n;
			if ($urandom_range(5) == 0)
				drain();
		end
	endtask

	initial begin
		failed = 0;
		idle_pct = 34;
		start = 1'b0;
		point_x = '0;
		point_y = '0;
		last_point = 1'b0;
		set_count = 0;
		set_overflow = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_small_sets();
		test_extremes();
		test_overflow();
		test_random_sets(35);
		// pause until all expected vertices have come
		drain();
		idle_pct = 48;
		test_random_sets(35);
		idle_pct = 0;
		test_random_sets(35);
		drain();
		repeat (50) @(posedge clk);
		if (failed)
			$display("*** FAILED ***");
		else
			$display("*** PASSED ***");
		$finish;
	end

endmodule
`default_nettype wire
